@@ hdl/cfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, result kind codes and helpers for the call target frequency
// profiler core.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // default sizes
  localparam int unsigned ENTRIES_DEF     = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // result kind codes
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_ENTRY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // input item as seen on the port
  typedef struct packed {
    logic        command;
    logic [31:0] target_id;
  } in_item_t;

  // result item as seen on the port
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] target_out;
    logic [3:0]  slot;
    logic [31:0] hit_count;
    logic        tracked;
    logic [31:0] untracked_out;
    logic [36:0] total_out;
    logic        last;
  } out_item_t;

  // classified request passed from the front queue to the table
  typedef enum logic {
    OP_REPORT,
    OP_DUMP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] target;
  } req_t;

  // saturating increment of a 32-bit count
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

@@ hdl/cfp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_queue
// Front part: accepts input items, classifies them as report or dump and
// holds them in a short queue until the table logic pops them.
// ----------------------------------------------------------------------------
module cfp_queue #(
  parameter int unsigned DEPTH = cfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cfp_pkg::in_item_t in_data_i,
  output logic             req_valid_o,
  output cfp_pkg::req_t    req_o,
  input  logic             pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cfp_pkg::req_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;
  cfp_pkg::req_t req_in;

  // classify the incoming item
  always_comb begin
    req_in.op     = in_data_i.command ? cfp_pkg::OP_DUMP : cfp_pkg::OP_REPORT;
    req_in.target = in_data_i.target_id;
  end

  assign in_stall_o  = (cnt_q == CW'(DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != '0);
  assign pop         = pop_i && req_valid_o;
  assign req_o       = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

@@ hdl/cfp_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_table
// Back part: the slot table with its counters, the dump sequencer (rank
// pass, then emission) and the output register.
// ----------------------------------------------------------------------------
module cfp_table #(
  parameter int unsigned ENTRIES = cfp_pkg::ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  cfp_pkg::req_t     req_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfp_pkg::out_item_t out_data_o
);

  localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [31:0]         target_q [ENTRIES];
  logic [31:0]         count_q  [ENTRIES];
  logic [31:0]         ovf_q;
  logic [SW-1:0]       rank_q   [ENTRIES];
  logic [SW-1:0]       j_q;
  logic [NW-1:0]       k_q;
  logic [36:0]         total_q;
  logic                out_valid_q;
  cfp_pkg::out_item_t  out_q;

  logic                out_free;
  logic                take;
  logic                load_out;
  logic [ENTRIES-1:0]  hit_vec, empty_vec, beat_vec, emit_vec;
  logic                hit_any, empty_any;
  logic [SW-1:0]       hit_idx, empty_idx, emit_idx;
  logic [31:0]         hit_new_count;
  logic [NW-1:0]       n_valid;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == ST_IDLE) && out_free;
  assign take        = pop_o && req_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign n_valid     = NW'($countones(valid_q));

  // output register is loaded by a report ack or by a dump emission
  assign load_out = (take && (req_i.op == cfp_pkg::OP_REPORT)) ||
                    ((state_q == ST_EMIT) && out_free);

  // match and free-slot search, lowest slot wins
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_q[i] && (target_q[i] == req_i.target);
      empty_vec[i] = !valid_q[i];
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SW'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = SW'(i);
      end
    end
    hit_any       = |hit_vec;
    empty_any     = |empty_vec;
    hit_new_count = cfp_pkg::sat_inc(count_q[hit_idx]);
  end

  // rank pass: slot j beats slot i on higher count or equal count and lower slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      beat_vec[i] = valid_q[j_q] && (j_q != SW'(i)) &&
                    ((count_q[j_q] > count_q[i]) ||
                     ((count_q[j_q] == count_q[i]) && (j_q < SW'(i))));
    end
  end

  // emission select: the valid slot whose rank equals the emit index
  always_comb begin
    emit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      emit_vec[i] = valid_q[i] && (NW'(rank_q[i]) == k_q);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (emit_vec[i]) begin
        emit_idx = SW'(i);
      end
    end
  end

  // slot identifiers, written when a report claims a free slot
  always_ff @(posedge clk_i) begin
    if (take && (req_i.op == cfp_pkg::OP_REPORT) && !hit_any && empty_any) begin
      target_q[empty_idx] <= req_i.target;
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      count_q     <= '{default: '0};
      rank_q      <= '{default: '0};
      ovf_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (req_i.op == cfp_pkg::OP_REPORT) begin
              out_q.kind          <= cfp_pkg::KIND_ACK;
              out_q.target_out    <= req_i.target;
              out_q.total_out     <= '0;
              out_q.last          <= 1'b1;
              if (hit_any) begin
                count_q[hit_idx]    <= hit_new_count;
                out_q.slot          <= 4'(hit_idx);
                out_q.hit_count     <= hit_new_count;
                out_q.tracked       <= 1'b1;
                out_q.untracked_out <= ovf_q;
              end else if (empty_any) begin
                valid_q[empty_idx]  <= 1'b1;
                count_q[empty_idx]  <= 32'd1;
                out_q.slot          <= 4'(empty_idx);
                out_q.hit_count     <= 32'd1;
                out_q.tracked       <= 1'b1;
                out_q.untracked_out <= ovf_q;
              end else begin
                ovf_q               <= cfp_pkg::sat_inc(ovf_q);
                out_q.untracked_out <= cfp_pkg::sat_inc(ovf_q);
                out_q.slot          <= '0;
                out_q.hit_count     <= '0;
                out_q.tracked       <= 1'b0;
              end
            end else begin
              j_q     <= '0;
              k_q     <= '0;
              total_q <= 37'(ovf_q);
              rank_q  <= '{default: '0};
              state_q <= ST_RANK;
            end
          end
        end
        ST_RANK: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (beat_vec[i]) begin
              rank_q[i] <= rank_q[i] + SW'(1);
            end
          end
          if (valid_q[j_q]) begin
            total_q <= total_q + 37'(count_q[j_q]);
          end
          if (j_q == SW'(ENTRIES - 1)) begin
            state_q <= ST_EMIT;
          end else begin
            j_q <= j_q + SW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q.untracked_out <= ovf_q;
            if (k_q == n_valid) begin
              out_q.kind       <= cfp_pkg::KIND_SUMMARY;
              out_q.target_out <= '0;
              out_q.slot       <= '0;
              out_q.hit_count  <= '0;
              out_q.tracked    <= 1'b0;
              out_q.total_out  <= total_q;
              out_q.last       <= 1'b1;
              state_q          <= ST_IDLE;
            end else begin
              out_q.kind       <= cfp_pkg::KIND_ENTRY;
              out_q.target_out <= target_q[emit_idx];
              out_q.slot       <= 4'(emit_idx);
              out_q.hit_count  <= count_q[emit_idx];
              out_q.tracked    <= 1'b1;
              out_q.total_out  <= '0;
              out_q.last       <= 1'b0;
              k_q              <= k_q + NW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/call_target_frequency_profiler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_target_frequency_profiler_core
// Counts hits per call target in a small table and dumps it sorted by count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries items with a
//   command bit: 0 reports one target id, 1 requests a sorted dump.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries results;
//   an item is moved when valid is high and stall is low.
//   A report gives one acknowledge result, through the queue and output register.
//   Reports sustain one item per cycle while the output is not stalled and
//   no dump is running; the table compares all slots in parallel and
//   updates in the same cycle. A dump runs a rank pass (one comparing slot
//   per cycle) and then emits the valid entries, highest count first, plus
//   a summary result with the untracked and total counts.
//   A short queue in front keeps taking items while the table is busy or
//   the output is stalled; in_stall_o rises only when that queue is full.
//   A stalled result holds in the output register and holds the table but
//   not ranking. Reset clears the table and every counter; no clearing pass.
// ----------------------------------------------------------------------------
module call_target_frequency_profiler_core #(
  parameter int unsigned ENTRIES     = cfp_pkg::ENTRIES_DEF,
  parameter int unsigned QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cfp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cfp_pkg::out_item_t out_data_o
);

  logic          req_valid;
  logic          req_pop;
  cfp_pkg::req_t req;

  // front: accept and classify
  cfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .pop_i       (req_pop)
  );

  // back: table update and dump
  cfp_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .pop_o       (req_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
